// ----- hw/rtl/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 8;
  localparam int STAT_W  = 2;
  localparam int FILL_W  = 5;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]         prio;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_ENQ,
    OP_DEQ
  } op_t;

  // Broadcast to every cell each cycle.
  typedef struct packed {
    op_t    op;
    entry_t new_entry;
  } ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/spq_cell.sv -----
// One slot of the sorted queue: compare against the new item, hold or shift.
`default_nettype none
module spq_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire spq_pkg::ctl_t   ctl,
  input  wire spq_pkg::entry_t left_entry,
  input  wire logic            left_valid,
  input  wire logic            left_keep,
  input  wire spq_pkg::entry_t right_entry,
  input  wire logic            right_valid,
  output spq_pkg::entry_t      entry,
  output logic                 valid,
  output logic                 keep
);

  spq_pkg::entry_t entry_r, entry_nxt;
  logic            valid_r, valid_nxt;

  // Sorted order makes keep a prefix of the chain.
  assign keep  = valid_r && (entry_r.prio <= ctl.new_entry.prio);
  assign entry = entry_r;
  assign valid = valid_r;

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    case (ctl.op)
      spq_pkg::OP_ENQ: begin
        if (!keep) begin
          if (left_keep) begin
            entry_nxt = ctl.new_entry;
            valid_nxt = 1'b1;
          end else begin
            entry_nxt = left_entry;
            valid_nxt = left_valid;
          end
        end
      end
      spq_pkg::OP_DEQ: begin
        entry_nxt = right_entry;
        valid_nxt = right_valid;
      end
      default: begin
        entry_nxt = entry_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/sorted_priority_queue_unit.sv -----
// Sorted priority queue: a row of DEPTH compare-and-shift slots, front at slot 0.
// The result is registered: it appears on the outputs in the cycle after the item is accepted.
// Throughput: one enqueue or dequeue per cycle while out_ready holds; every slot updates in parallel.
// Output register frees the input whenever the held result is taken.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result.
`default_nettype none
module sorted_priority_queue_unit #(
  parameter int DEPTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_kind,
  input  wire logic signed [spq_pkg::VALUE_W-1:0] in_item_value,
  input  wire logic [spq_pkg::PRIO_W-1:0]         in_priority_req,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [spq_pkg::STAT_W-1:0]              out_status,
  output logic                                   out_out_valid,
  output logic signed [spq_pkg::VALUE_W-1:0]      out_out_value,
  output logic [spq_pkg::PRIO_W-1:0]              out_out_priority,
  output logic [spq_pkg::FILL_W-1:0]              out_fill_count
);

  localparam int OCC_W = $clog2(DEPTH + 1);

  spq_pkg::ctl_t   ctl;
  spq_pkg::entry_t entry_w [DEPTH];
  logic            valid_w [DEPTH];
  logic            keep_w  [DEPTH];

  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             full, empty, accept;

  logic                               out_valid_r, out_valid_nxt;
  logic [spq_pkg::STAT_W-1:0]         status_r, status_nxt;
  logic                               ent_valid_r, ent_valid_nxt;
  logic signed [spq_pkg::VALUE_W-1:0] value_r, value_nxt;
  logic [spq_pkg::PRIO_W-1:0]         prio_r, prio_nxt;
  logic [spq_pkg::FILL_W-1:0]         fill_r, fill_nxt;

  assign full     = (occ_r == OCC_W'(DEPTH));
  assign empty    = (occ_r == '0);
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ctl.new_entry.value = in_item_value;
    ctl.new_entry.prio  = in_priority_req;
    ctl.op              = spq_pkg::OP_HOLD;
    occ_nxt             = occ_r;
    status_nxt          = status_r;
    ent_valid_nxt       = ent_valid_r;
    value_nxt           = value_r;
    prio_nxt            = prio_r;
    fill_nxt            = fill_r;
    out_valid_nxt       = out_valid_r && !out_ready;
    if (accept) begin
      out_valid_nxt = 1'b1;
      status_nxt    = spq_pkg::ST_DONE;
      ent_valid_nxt = 1'b0;
      value_nxt     = '0;
      prio_nxt      = '0;
      if (in_kind == spq_pkg::KIND_ENQ) begin
        if (full) begin
          status_nxt = spq_pkg::ST_OVERFLOW;
        end else begin
          ctl.op  = spq_pkg::OP_ENQ;
          occ_nxt = occ_r + OCC_W'(1);
        end
      end else begin
        if (empty) begin
          status_nxt = spq_pkg::ST_UNDERFLOW;
        end else begin
          ctl.op        = spq_pkg::OP_DEQ;
          occ_nxt       = occ_r - OCC_W'(1);
          ent_valid_nxt = 1'b1;
          value_nxt     = entry_w[0].value;
          prio_nxt      = entry_w[0].prio;
        end
      end
      fill_nxt = spq_pkg::FILL_W'(occ_nxt);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_entry, right_entry;
    logic            left_valid, left_keep, right_valid;

    if (i == 0) begin : g_head
      // Insertion lands at the front when no slot keeps its place.
      assign left_entry = ctl.new_entry;
      assign left_valid = 1'b0;
      assign left_keep  = 1'b1;
    end else begin : g_mid
      assign left_entry = entry_w[i-1];
      assign left_valid = valid_w[i-1];
      assign left_keep  = keep_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = ctl.new_entry;
      assign right_valid = 1'b0;
    end else begin : g_body
      assign right_entry = entry_w[i+1];
      assign right_valid = valid_w[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_entry  (left_entry),
      .left_valid  (left_valid),
      .left_keep   (left_keep),
      .right_entry (right_entry),
      .right_valid (right_valid),
      .entry       (entry_w[i]),
      .valid       (valid_w[i]),
      .keep        (keep_w[i])
    );
  end

  always_ff @(posedge clk) begin
    status_r    <= status_nxt;
    ent_valid_r <= ent_valid_nxt;
    value_r     <= value_nxt;
    prio_r      <= prio_nxt;
    fill_r      <= fill_nxt;
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_out_valid    = ent_valid_r;
  assign out_out_value    = value_r;
  assign out_out_priority = prio_r;
  assign out_fill_count   = fill_r;

endmodule
`default_nettype wire
